[design/assert_macros.svh]
// Assertion macros shared by the frame buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[design/i2csfb_pkg.sv]
// Types and constants of the two-wire slave frame buffer.
`default_nettype none
package i2csfb_pkg;

    localparam int FRAME_LEN       = 8;
    localparam int PORT_OFFSET     = 0;
    localparam int FUNCTION_OFFSET = 1;
    localparam int PORT_COUNT      = 11;

    localparam int IDX_W  = 6;
    localparam int ADDR_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

    typedef enum logic [2:0] {
        CMD_ADDR_WRITE = 3'd0,
        CMD_DATA_ACK   = 3'd1,
        CMD_DATA_NACK  = 3'd2,
        CMD_STOP       = 3'd3,
        CMD_ADDR_READ  = 3'd4,
        CMD_SENT_ACK   = 3'd5,
        CMD_SENT_LAST  = 3'd6,
        CMD_OTHER      = 3'd7
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic       ack_next;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_ready;
        logic [7:0] frame_port;
        logic [7:0] frame_function;
        logic       port_invalid;
    } t_out_word;

endpackage
`default_nettype wire

[design/i2csfb_core.sv]
// Frame store, byte index and valid flag, updated by one bus event per step.
`default_nettype none
`include "assert_macros.svh"
module i2csfb_core
    import i2csfb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic      i_step,
    input  wire t_in_word  i_word,
    output t_out_word      o_result
);

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W:0]    LEN_EXT   = (IDX_W + 1)'(FRAME_LEN);
    localparam logic [ADDR_W-1:0] PORT_ADDR = ADDR_W'(PORT_OFFSET % FRAME_LEN);
    localparam logic [ADDR_W-1:0] FUNC_ADDR = ADDR_W'(FUNCTION_OFFSET % FRAME_LEN);
    localparam logic [8:0]        PORT_LIM  = 9'(PORT_COUNT);

    logic [7:0]       r_error_code;
    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic             r_frame_valid, n_frame_valid;
    logic [7:0]       r_store [FRAME_LEN];
    logic [7:0]       n_store [FRAME_LEN];
    logic [7:0]       err_frame [FRAME_LEN];

    logic              idx_ok;
    logic              idx_last;
    logic [ADDR_W-1:0] idx_addr;
    logic [7:0]        port_byte;
    logic [7:0]        func_byte;
    t_out_word         res;

    assign idx_ok   = ({1'b0, r_byte_index} < LEN_EXT);
    assign idx_last = (r_byte_index == LAST_IDX);
    assign idx_addr = r_byte_index[ADDR_W-1:0];

    // Offsets that fall outside the frame read as zero.
    assign port_byte = (PORT_OFFSET < FRAME_LEN) ? r_store[PORT_ADDR] : 8'h00;
    assign func_byte = (FUNCTION_OFFSET < FRAME_LEN) ? r_store[FUNC_ADDR] : 8'h00;

    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            err_frame[i] = (i == 1) ? r_error_code : 8'h00;
        end
    end

    always_comb begin
        n_byte_index  = r_byte_index;
        n_frame_valid = r_frame_valid;
        n_store       = r_store;
        res           = '0;
        case (i_word.cmd)
            CMD_ADDR_WRITE: begin
                n_byte_index  = '0;
                n_frame_valid = 1'b0;
                res.ack_next  = 1'b1;
            end
            CMD_DATA_ACK: begin
                if (idx_ok) begin
                    n_store[idx_addr] = i_word.rx_byte;
                end
                if (!idx_last) begin
                    n_byte_index = r_byte_index + 1'b1;
                    res.ack_next = 1'b1;
                end
            end
            CMD_DATA_NACK: begin
                n_byte_index = '0;
            end
            CMD_STOP: begin
                res.ack_next = 1'b1;
                if (idx_last) begin
                    n_frame_valid      = 1'b1;
                    res.frame_ready    = 1'b1;
                    res.frame_port     = port_byte;
                    res.frame_function = func_byte;
                    res.port_invalid   = ({1'b0, port_byte} >= PORT_LIM);
                end else begin
                    n_frame_valid = 1'b0;
                    n_store       = err_frame;
                end
            end
            CMD_ADDR_READ: begin
                // With no valid frame the error frame goes out, whose first byte is zero.
                if (!r_frame_valid) begin
                    n_store = err_frame;
                end
                res.tx_valid = 1'b1;
                res.tx_byte  = r_frame_valid ? r_store[0] : 8'h00;
                n_byte_index = IDX_W'(1);
                res.ack_next = 1'b1;
            end
            CMD_SENT_ACK: begin
                res.tx_valid = 1'b1;
                res.tx_byte  = idx_ok ? r_store[idx_addr] : 8'h00;
                if (!idx_last) begin
                    n_byte_index = r_byte_index + 1'b1;
                    res.ack_next = 1'b1;
                end
            end
            CMD_SENT_LAST: begin
                n_byte_index  = '0;
                n_frame_valid = 1'b0;
                res.ack_next  = 1'b1;
            end
            default: begin
                res.ack_next = 1'b0;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_code  <= 8'hFF;
            r_byte_index  <= '0;
            r_frame_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_error_code <= i_cfg_data;
            end
            if (i_step) begin
                r_byte_index  <= n_byte_index;
                r_frame_valid <= n_frame_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_store <= n_store;
        end
    end

    `ASSERT_IMPLIES(a_idx_in_frame, i_clk, i_rst_n, 1'b1, idx_ok)
    `ASSERT_IMPLIES(a_valid_by_stop, i_clk, i_rst_n, $rose(r_frame_valid), $past(i_step && (i_word.cmd == CMD_STOP)))
    `ASSERT_NEXT(a_read_index, i_clk, i_rst_n, i_step && (i_word.cmd == CMD_ADDR_READ), r_byte_index == IDX_W'(1))

endmodule
`default_nettype wire

[design/i2c_slave_frame_buffer_top.sv]
// Two-wire slave frame buffer: input and result registers around the event logic.
//
// Usage:
// The input channel (i_in_valid, i_in_word, o_in_stall) carries one bus event
// per word: the event code and, for a received data byte, that byte. The
// result channel (o_out_valid, o_out_word, i_out_stall) returns exactly one
// word per event: acknowledge enable for the next byte, the byte to transmit
// on read events, and the port and function bytes when a stop accepts a frame.
// The error code register is written through i_cfg_we and i_cfg_data. The user
// must write it only while no event is in flight; the block has no such check.
// An event is taken into the input register and its result word into the
// result register, from which it is offered. One event is accepted every cycle
// while the receiver does not stall; the state update for an event is computed
// between the input register and the result register.
// Synchronous reset empties both registers, clears the byte index and the
// valid flag, and sets the error code to 0xFF; the frame store keeps no reset
// value. When the receiver stalls, the result word holds, one further event
// waits in the input register, and then o_in_stall rises.
`default_nettype none
`include "assert_macros.svh"
module i2c_slave_frame_buffer_top
    import i2csfb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    input  wire t_in_word   i_in_word,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output t_out_word       o_out_word,
    input  wire logic       i_out_stall
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      out_free;
    logic      advance;
    logic      in_take;
    t_out_word core_result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    i2csfb_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (advance),
        .i_word     (r_in_word),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `ASSERT_NEXT(a_held_word_kept, i_clk, i_rst_n, r_in_valid && !out_free, r_in_valid)
    `ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, advance, r_out_valid)
    `ASSERT_IMPLIES(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall, r_out_valid && r_in_valid)

endmodule
`default_nettype wire
